// File: sv/decimal_stream_long_divider_assert.svh
// Assertion helpers for the decimal stream long divider.
`ifndef DECIMAL_STREAM_LONG_DIVIDER_ASSERT_SVH
`define DECIMAL_STREAM_LONG_DIVIDER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define DSLD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define DSLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/dsld_pkg.sv
package dsld_pkg;

    localparam int DIVISOR_BITS_DEF = 31;
    localparam int ADDR_BITS        = 1;

    localparam logic [ADDR_BITS-1:0] REG_DIVISOR = 1'b0;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [3:0] DIGIT_MAX = 4'd9;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REP,
        S_SER,
        S_DONE
    } t_state;

endpackage

// File: sv/decimal_stream_long_divider.sv
// Channel  Dir  Bus     Payload
// input    in   s_axis  tdata char_in; tlast last_char
// result   out  m_axis  q_digit/digit_emitted/final_remainder; tlast is_last; tuser error_flag
// config   in   apb     divisor at address 0
//
// One transaction at a time; one shared subtract/compare unit does all the work.
// Digit with remainder below divisor: repeated subtraction, one subtraction per quotient step.
// Remainder at or above divisor (divisor rewritten mid-number): restoring division,
// one restoring bit step per cycle. Non-digit or zero divisor: straight to the result.
// Synchronous active-low reset; no clearing pass. A stalled result holds the unit;
// the next input transaction is taken while a result waits at the output register.
`include "decimal_stream_long_divider_assert.svh"

module decimal_stream_long_divider #(
    parameter  int DIVISOR_BITS = dsld_pkg::DIVISOR_BITS_DEF,
    localparam int DataBits     = (DIVISOR_BITS > 32) ? 64 : 32,
    localparam int OutBits      = ((DIVISOR_BITS + 5 + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] char_in
    input  logic                           s_axis_tlast,   // last_char

    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [3:0] q_digit, [4] digit_emitted, [DIVISOR_BITS+4:5] final_remainder, rest 0
    output logic [OutBits-1:0]             m_axis_tdata,
    output logic                           m_axis_tlast,   // is_last
    output logic                           m_axis_tuser,   // [0] error_flag

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dsld_pkg::ADDR_BITS-1:0] paddr,
    input  logic [DataBits-1:0]            pwdata,
    output logic [DataBits-1:0]            prdata,
    output logic                           pready
);

    localparam int SegBits = DIVISOR_BITS + 4;
    localparam int CntBits = $clog2(SegBits + 1);

    dsld_pkg::t_state r_state, n_state;

    logic [DIVISOR_BITS-1:0] r_div, n_div;
    logic [DIVISOR_BITS-1:0] r_rem, n_rem;
    logic                    r_started, n_started;
    logic                    r_sticky, n_sticky;

    logic [SegBits-1:0]      r_acc, n_acc;
    logic [SegBits-1:0]      r_dvd, n_dvd;
    logic [CntBits-1:0]      r_cnt, n_cnt;
    logic [3:0]              r_qcnt, n_qcnt;
    logic                    r_ovf, n_ovf;
    logic                    r_err_step, n_err_step;
    logic                    r_last, n_last;

    logic                    r_m_valid, n_m_valid;
    logic [3:0]              r_m_qd, n_m_qd;
    logic                    r_m_emit, n_m_emit;
    logic [DIVISOR_BITS-1:0] r_m_rem, n_m_rem;
    logic                    r_m_last, n_m_last;
    logic                    r_m_err, n_m_err;

    logic                    in_acc;
    logic                    cfg_wr;
    logic                    bad_char;
    logic [7:0]              ch_off;
    logic [SegBits-1:0]      seg;
    logic [SegBits-1:0]      op_x;
    logic [SegBits:0]        diff;
    logic                    ge;
    logic                    out_free;
    logic                    commit;

    logic                    q_pos;
    logic [3:0]              qd_sat;
    logic                    c_sticky;
    logic [DIVISOR_BITS-1:0] c_rem;
    logic                    c_emit;
    logic                    c_started;
    logic [3:0]              c_qd;

    assign s_axis_tready = (r_state == dsld_pkg::S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == dsld_pkg::REG_DIVISOR) ? DataBits'(r_div) : '0;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OutBits'({r_m_rem, r_m_emit, r_m_qd});
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tuser  = r_m_err;

    // segment = remainder * 10 + digit
    assign ch_off   = s_axis_tdata - dsld_pkg::CHAR_ZERO;
    assign bad_char = (s_axis_tdata < dsld_pkg::CHAR_ZERO) ||
                      (s_axis_tdata > dsld_pkg::CHAR_NINE) || (r_div == '0);
    assign seg      = {1'b0, r_rem, 3'b000} + {3'b000, r_rem, 1'b0} +
                      {{(SegBits-4){1'b0}}, ch_off[3:0]};

    // shared subtract/compare unit
    assign op_x = (r_state == dsld_pkg::S_SER) ?
                  {3'b000, r_acc[DIVISOR_BITS-1:0], r_dvd[SegBits-1]} : r_acc;
    assign diff = {1'b0, op_x} - {5'b00000, r_div};
    assign ge   = !diff[SegBits];

    assign commit = out_free && (((r_state == dsld_pkg::S_REP) && !ge) ||
                                 (r_state == dsld_pkg::S_DONE));

    always_comb begin
        q_pos     = r_ovf || (r_qcnt != 4'd0);
        qd_sat    = (r_ovf || (r_qcnt > dsld_pkg::DIGIT_MAX)) ? dsld_pkg::DIGIT_MAX : r_qcnt;
        c_sticky  = r_sticky || r_err_step;
        c_rem     = r_err_step ? r_rem : r_acc[DIVISOR_BITS-1:0];
        c_emit    = !r_err_step && !r_sticky && (q_pos || r_started);
        c_started = r_started || c_emit;
        c_qd      = (r_err_step || r_sticky) ? 4'd0 : qd_sat;
        if (r_last && !c_sticky && !c_started) begin
            c_qd   = 4'd0;
            c_emit = 1'b1;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_div      = r_div;
        n_rem      = r_rem;
        n_started  = r_started;
        n_sticky   = r_sticky;
        n_acc      = r_acc;
        n_dvd      = r_dvd;
        n_cnt      = r_cnt;
        n_qcnt     = r_qcnt;
        n_ovf      = r_ovf;
        n_err_step = r_err_step;
        n_last     = r_last;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_qd     = r_m_qd;
        n_m_emit   = r_m_emit;
        n_m_rem    = r_m_rem;
        n_m_last   = r_m_last;
        n_m_err    = r_m_err;

        if (cfg_wr && (paddr == dsld_pkg::REG_DIVISOR)) begin
            n_div = pwdata[DIVISOR_BITS-1:0];
        end

        unique case (r_state)
            dsld_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_last     = s_axis_tlast;
                    n_qcnt     = 4'd0;
                    n_ovf      = 1'b0;
                    n_err_step = bad_char;
                    n_dvd      = seg;
                    n_cnt      = CntBits'(SegBits);
                    if (bad_char) begin
                        n_state = dsld_pkg::S_DONE;
                    end else if (r_rem < r_div) begin
                        n_acc   = seg;
                        n_state = dsld_pkg::S_REP;
                    end else begin
                        n_acc   = '0;
                        n_state = dsld_pkg::S_SER;
                    end
                end
            end
            dsld_pkg::S_REP: begin
                if (ge) begin
                    n_acc  = diff[SegBits-1:0];
                    n_qcnt = r_qcnt + 4'd1;
                end else if (out_free) begin
                    n_state = dsld_pkg::S_IDLE;
                end
            end
            dsld_pkg::S_SER: begin
                if (r_cnt != '0) begin
                    n_acc  = ge ? {4'b0000, diff[DIVISOR_BITS-1:0]} :
                                  {4'b0000, op_x[DIVISOR_BITS-1:0]};
                    n_dvd  = {r_dvd[SegBits-2:0], 1'b0};
                    n_qcnt = {r_qcnt[2:0], ge};
                    n_ovf  = r_ovf || r_qcnt[3];
                    n_cnt  = r_cnt - CntBits'(1);
                end else begin
                    n_state = dsld_pkg::S_DONE;
                end
            end
            dsld_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = dsld_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dsld_pkg::S_IDLE;
            end
        endcase

        if (commit) begin
            n_m_valid = 1'b1;
            n_m_qd    = c_qd;
            n_m_emit  = c_emit;
            n_m_rem   = (r_last && !c_sticky) ? c_rem : '0;
            n_m_last  = r_last;
            n_m_err   = c_sticky;
            n_rem     = r_last ? '0 : c_rem;
            n_started = r_last ? 1'b0 : c_started;
            n_sticky  = r_last ? 1'b0 : c_sticky;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dsld_pkg::S_IDLE;
            r_div     <= DIVISOR_BITS'(1);
            r_rem     <= '0;
            r_started <= 1'b0;
            r_sticky  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_div     <= n_div;
            r_rem     <= n_rem;
            r_started <= n_started;
            r_sticky  <= n_sticky;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_dvd      <= n_dvd;
        r_cnt      <= n_cnt;
        r_qcnt     <= n_qcnt;
        r_ovf      <= n_ovf;
        r_err_step <= n_err_step;
        r_last     <= n_last;
        r_m_qd     <= n_m_qd;
        r_m_emit   <= n_m_emit;
        r_m_rem    <= n_m_rem;
        r_m_last   <= n_m_last;
        r_m_err    <= n_m_err;
    end

    `DSLD_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_axis_tready,
                      "input accepted while a transaction is in progress")
    `DSLD_ASSERT_NOW(a_digit_range, r_m_valid, r_m_qd <= dsld_pkg::DIGIT_MAX,
                     "quotient digit above nine")
    `DSLD_ASSERT_NOW(a_err_no_rem, r_m_valid && r_m_err, r_m_rem == '0,
                     "remainder reported on an errored number")
    `DSLD_ASSERT_NEXT(a_last_clears, commit && r_last,
                      (r_rem == '0) && !r_started && !r_sticky,
                      "number state not cleared after last character")

endmodule
